/* sv/ubid_pkg.sv */
// ubid_pkg: shared codes, widths and reset values for the uart break and idle detector
// no dependencies; imported by every module of the block

package ubid_pkg;

	// field widths
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned EVENT_W   = 2;
	localparam int unsigned BRK_W     = 14;
	localparam int unsigned IDLE_TO_W = 24;
	localparam int unsigned IDLE_W    = 25;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK         = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BRK_REFRESH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE_REFRESH = 2'd2;

	// event codes
	localparam logic [EVENT_W-1:0] EV_NONE        = 2'd0;
	localparam logic [EVENT_W-1:0] EV_BREAK_START = 2'd1;
	localparam logic [EVENT_W-1:0] EV_BREAK_END   = 2'd2;
	localparam logic [EVENT_W-1:0] EV_IDLE        = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_END    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd3;

	// register reset values
	localparam logic [BRK_W-1:0] BREAK_START_RST = 14'd1000;
	localparam logic [BRK_W-1:0] BREAK_END_RST   = 14'd10000;

	// configuration as seen by the counting logic, with clear strobes
	typedef struct packed {
		logic                 break_enable;
		logic [BRK_W-1:0]     break_start_ticks;
		logic [BRK_W-1:0]     break_end_ticks;
		logic [IDLE_TO_W-1:0] idle_timeout;
		logic                 clr_break;
		logic                 clr_idle;
	} cfg_t;

	// one item held in the input stage
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              rx_level;
	} item_t;

endpackage

/* sv/uart_break_idle_detector_top.sv */
// uart_break_idle_detector_top: one channel of uart break and idle line detection
// depends on ubid_pkg, ubid_cfg, ubid_in_stage, ubid_core
//
// Usage: feed one item per millisecond tick (mode tick, with the sampled rx level)
// or a break / idle refresh request on the input channel. Each item gives exactly
// one result: event_res (none, break start, break end, idle timeout) and in_break,
// the break state after that item.
// Channels: valid/stall on both sides; a transfer happens on a clock edge with
// valid high and stall low. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); the user must write it only while no item is in
// flight, and the block itself does not enforce this.
// Pipeline: input register, then the counter update into the result register.
// Throughput: one item per cycle while the output does not stall, set by the
// single counter update between the two registers.
// Stall: while the result waits, one more item is taken into the input register;
// after that in_stall follows the output stall.
// Reset (arst_n low): counts and break state cleared, break detection off,
// start limit 1000, end limit 10000, idle detection off, both channels empty.

module uart_break_idle_detector_top import ubid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MODE_W-1:0]    mode,
	input  logic                 rx_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [EVENT_W-1:0]   event_res,
	output logic                 in_break,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  take;

	ubid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ubid_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.rx_level (rx_level),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ubid_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.in_break  (in_break)
	);

endmodule

/* sv/ubid_cfg.sv */
// ubid_cfg: configuration registers of the detector and the count clear strobes
// depends on ubid_pkg

module ubid_cfg import ubid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	logic                 break_enable_q;
	logic [BRK_W-1:0]     break_start_q;
	logic [BRK_W-1:0]     break_end_q;
	logic [IDLE_TO_W-1:0] idle_timeout_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_enable_q <= 1'b0;
			break_start_q  <= BREAK_START_RST;
			break_end_q    <= BREAK_END_RST;
			idle_timeout_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BREAK_ENABLE: break_enable_q <= cfg_data[0];
				REG_BREAK_START:  break_start_q  <= cfg_data[BRK_W-1:0];
				REG_BREAK_END:    break_end_q    <= cfg_data[BRK_W-1:0];
				REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data[IDLE_TO_W-1:0];
				default:          break_enable_q <= break_enable_q;
			endcase
		end
	end

	// register view and clear strobes for the counters
	always_comb begin
		cfg.break_enable      = break_enable_q;
		cfg.break_start_ticks = break_start_q;
		cfg.break_end_ticks   = break_end_q;
		cfg.idle_timeout      = idle_timeout_q;
		cfg.clr_break         = cfg_we && (cfg_index == REG_BREAK_ENABLE);
		cfg.clr_idle          = cfg_we && (cfg_index == REG_IDLE_TIMEOUT);
	end

endmodule

/* sv/ubid_in_stage.sv */
// ubid_in_stage: input register of the detector pipeline
// depends on ubid_pkg

module ubid_in_stage import ubid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic              rx_level,
	input  logic              take,
	output logic              valid_s1,
	output item_t             item_s1
);

	logic load;

	// the stage frees up whenever its item moves on
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !take);
		end
	end

	// payload, captured on each input transfer
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.mode     <= mode;
			item_s1.rx_level <= rx_level;
		end
	end

endmodule

/* sv/ubid_core.sv */
// ubid_core: break and idle counters, event decision and result register
// depends on ubid_pkg

module ubid_core import ubid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               valid_s1,
	input  item_t              item_s1,
	output logic               take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [EVENT_W-1:0] event_res,
	output logic               in_break
);

	logic [BRK_W-1:0]  break_count_q;
	logic              break_active_q;
	logic [IDLE_W-1:0] idle_count_q;

	logic              is_tick;
	logic [BRK_W:0]    brk_next;
	logic [BRK_W-1:0]  brk_limit;
	logic              brk_fire;
	logic [IDLE_W:0]   idle_next;
	logic              idle_fire;

	logic [BRK_W-1:0]   break_count_d;
	logic               break_active_d;
	logic [IDLE_W-1:0]  idle_count_d;
	logic [EVENT_W-1:0] event_d;

	// item leaves the input stage when the result register can take it
	assign take = valid_s1 && (!out_valid || !out_stall);

	// break counting
	always_comb begin
		is_tick   = (item_s1.mode == MODE_TICK);
		brk_next  = {1'b0, break_count_q} + {{BRK_W{1'b0}}, 1'b1};
		brk_limit = break_active_q ? cfg.break_end_ticks : cfg.break_start_ticks;
		brk_fire  = 1'b0;

		break_count_d  = break_count_q;
		break_active_d = break_active_q;
		if (item_s1.mode == MODE_BRK_REFRESH) begin
			break_count_d = '0;
		end else if (is_tick && cfg.break_enable && (item_s1.rx_level == break_active_q)) begin
			if (brk_next > {1'b0, brk_limit}) begin
				brk_fire       = 1'b1;
				break_active_d = !break_active_q;
				break_count_d  = '0;
			end else begin
				break_count_d = brk_next[BRK_W-1:0];
			end
		end
	end

	// idle counting, sees the updated break state
	always_comb begin
		idle_next    = {1'b0, idle_count_q} + {{IDLE_W{1'b0}}, 1'b1};
		idle_fire    = 1'b0;
		idle_count_d = idle_count_q;
		if (item_s1.mode == MODE_IDLE_REFRESH) begin
			idle_count_d = '0;
		end else if (is_tick && (cfg.idle_timeout != '0)) begin
			if (break_active_d) begin
				idle_count_d = '0;
			end else if (idle_next > {2'b00, cfg.idle_timeout}) begin
				idle_fire    = 1'b1;
				idle_count_d = '0;
			end else begin
				idle_count_d = idle_next[IDLE_W-1:0];
			end
		end
	end

	// break events take precedence over idle
	always_comb begin
		priority if (brk_fire) begin
			event_d = break_active_q ? EV_BREAK_END : EV_BREAK_START;
		end else if (idle_fire) begin
			event_d = EV_IDLE;
		end else begin
			event_d = EV_NONE;
		end
	end

	// counter state, cleared by register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_count_q  <= '0;
			break_active_q <= 1'b0;
			idle_count_q   <= '0;
		end else begin
			if (cfg.clr_break) begin
				break_count_q  <= '0;
				break_active_q <= 1'b0;
			end else if (take) begin
				break_count_q  <= break_count_d;
				break_active_q <= break_active_d;
			end
			if (cfg.clr_idle) begin
				idle_count_q <= '0;
			end else if (take) begin
				idle_count_q <= idle_count_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= take || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			event_res <= event_d;
			in_break  <= break_active_d;
		end
	end

endmodule
